### rtl/core/assert_macros.svh
// assertion macros for the rtl file that checks its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/mnsq_pkg.sv
// types and constants of the melody note sequencer
`timescale 1ns / 1ps
`default_nettype none
package mnsq_pkg;

  // action codes of an input request
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // floor(d/5) = (d * DIV5_MUL) >> DIV5_SHIFT, exact for any 16-bit d
  localparam logic [16:0] DIV5_MUL   = 17'd52429;
  localparam int          DIV5_SHIFT = 18;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  entry_index;
    logic [15:0] entry_freq;
    logic [15:0] entry_duration;
    logic [8:0]  melody_length;
  } mnsq_req_t;

  typedef struct packed {
    logic [15:0] tone_freq;
    logic        sounding;
    logic        playing;
    logic        finished;
    logic [8:0]  note_position;
  } mnsq_rsp_t;

endpackage
`default_nettype wire

### rtl/core/mnsq_note_mem.sv
// note table: one synchronous memory of frequency and duration per entry
`timescale 1ns / 1ps
`default_nettype none
module mnsq_note_mem #(
  parameter int DEPTH     = 256,
  parameter int AW        = 8,
  parameter int FREQ_BITS = 16
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [FREQ_BITS-1:0] wr_freq,
  input  logic [15:0]          wr_dur,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [FREQ_BITS-1:0] rd_freq,
  output logic [15:0]          rd_dur
);

  logic [FREQ_BITS+15:0] mem [DEPTH];
  logic [FREQ_BITS+15:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_freq, wr_dur};
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_freq = rd_q_r[FREQ_BITS+15:16];
  assign rd_dur  = rd_q_r[15:0];

endmodule
`default_nettype wire

### rtl/core/melody_note_sequencer_unit.sv
// top level of the melody note sequencer: control sequencer around the note table
`timescale 1ns / 1ps
`default_nettype none
// The sequencer plays notes out of a table held in one synchronous memory
// (frequency and duration per entry, written by load requests) and answers
// every request with exactly one status result. Requests are taken one at a
// time: a load, an idle tick or a start of length zero goes from idle to
// emit; a start adds the sound state (one memory read of entry 0); a playing
// tick adds scale, sum and test, and sound when it moves to the next note.
// A playing tick reads the note duration, forms duration*6/5 as
// duration + duration/5 through a registered reciprocal multiply, then runs
// the staccato compare (elapsed*10 > scaled*9) and the end-of-note compare;
// a note change costs a second read of the same memory port for the new
// frequency. The next request is taken in the cycle after the result is
// loaded into the output register; a result-side stall holds the emit state,
// delaying that load and the next request. The table has no reset: entries
// read before they are written return whatever the memory holds.
module melody_note_sequencer_unit #(
  parameter int TABLE_DEPTH = 256,
  parameter int FREQ_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mnsq_pkg::mnsq_req_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mnsq_pkg::mnsq_rsp_t out_data
);
  import mnsq_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [12:0] DEPTH_W = 13'(TABLE_DEPTH);

  // one-hot sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCALE = 6'b000010,
    S_SUM   = 6'b000100,
    S_TEST  = 6'b001000,
    S_SOUND = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  logic [8:0]  index_r, index_nxt;
  logic [8:0]  len_r, len_nxt;
  logic [16:0] elapsed_r, elapsed_nxt;
  logic [16:0] scaled_r, scaled_nxt;
  logic        playing_r, playing_nxt;
  logic        tone_r, tone_nxt;
  logic [15:0] freq_r, freq_nxt;
  logic        fin_r, fin_nxt;
  logic [32:0] prod_r, prod_nxt;
  logic        out_valid_r;
  mnsq_rsp_t   out_data_r;

  // memory port signals
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [FREQ_BITS-1:0] wr_freq;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [8:0]           rd_index;
  logic [FREQ_BITS-1:0] rd_freq;
  logic [15:0]          rd_dur;

  // helpers
  logic        accept;
  logic        emit_ok;
  logic [12:0] wr_index_w;
  logic [12:0] rd_index_w;
  logic [12:0] mlen_w;
  logic [8:0]  len_sat;
  logic [39:0] in_freq_w;
  logic [39:0] rd_freq_w;
  logic [15:0] rd_freq16;
  logic [8:0]  idx_inc;
  logic [20:0] elapsed_x10;
  logic [20:0] scaled_x9;
  logic        cut;
  logic        note_done;
  logic        last_note;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign emit_ok  = !out_valid_r || !out_stall;

  // table write on a load request, ignored past the end of the table
  assign wr_index_w = 13'(in_data.entry_index);
  assign wr_addr    = wr_index_w[AW-1:0];
  assign in_freq_w  = 40'(in_data.entry_freq);
  assign wr_freq    = in_freq_w[FREQ_BITS-1:0];
  assign wr_en      = accept && (in_data.action == ACT_LOAD) && (wr_index_w < DEPTH_W);

  // frequency as driven to the tone generator
  assign rd_freq_w = 40'(rd_freq);
  assign rd_freq16 = rd_freq_w[15:0];

  // length saturates at the table depth
  assign mlen_w  = 13'(in_data.melody_length);
  assign len_sat = (mlen_w > DEPTH_W) ? DEPTH_W[8:0] : in_data.melody_length;

  // staccato and end-of-note tests on the registered elapsed and scaled values
  assign elapsed_x10 = {1'b0, elapsed_r, 3'b000} + {3'b000, elapsed_r, 1'b0};
  assign scaled_x9   = {1'b0, scaled_r, 3'b000} + {4'b0000, scaled_r};
  assign cut         = elapsed_x10 > scaled_x9;
  assign note_done   = elapsed_r >= scaled_r;
  assign idx_inc     = index_r + 9'd1;
  assign last_note   = idx_inc >= len_r;

  assign rd_index_w = 13'(rd_index);
  assign rd_addr    = rd_index_w[AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    index_nxt   = index_r;
    len_nxt     = len_r;
    elapsed_nxt = elapsed_r;
    scaled_nxt  = scaled_r;
    playing_nxt = playing_r;
    tone_nxt    = tone_r;
    freq_nxt    = freq_r;
    fin_nxt     = fin_r;
    prod_nxt    = prod_r;
    rd_en       = 1'b0;
    rd_index    = index_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EMIT;
          case (in_data.action)
            ACT_LOAD: begin
              state_nxt = S_EMIT;
            end
            ACT_START: begin
              index_nxt   = '0;
              elapsed_nxt = '0;
              if (in_data.melody_length == 9'd0) begin
                len_nxt     = '0;
                playing_nxt = 1'b0;
                tone_nxt    = 1'b0;
                freq_nxt    = '0;
                scaled_nxt  = '0;
              end else begin
                // fetch entry 0 and sound it
                len_nxt     = len_sat;
                playing_nxt = 1'b1;
                rd_en       = 1'b1;
                rd_index    = '0;
                state_nxt   = S_SOUND;
              end
            end
            ACT_TICK: begin
              if (playing_r) begin
                rd_en     = 1'b1;
                rd_index  = index_r;
                state_nxt = S_SCALE;
              end
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_SCALE: begin
        // quotient by five via reciprocal
        prod_nxt  = 33'(rd_dur) * 33'(DIV5_MUL);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        scaled_nxt  = 17'(rd_dur) + 17'(prod_r[32:DIV5_SHIFT]);
        elapsed_nxt = elapsed_r + 17'd1;
        state_nxt   = S_TEST;
      end
      S_TEST: begin
        state_nxt = S_EMIT;
        if (cut) begin
          tone_nxt = 1'b0;
        end
        if (note_done) begin
          elapsed_nxt = '0;
          index_nxt   = idx_inc;
          if (last_note) begin
            playing_nxt = 1'b0;
            tone_nxt    = 1'b0;
            freq_nxt    = '0;
            fin_nxt     = 1'b1;
          end else begin
            rd_en     = 1'b1;
            rd_index  = idx_inc;
            state_nxt = S_SOUND;
          end
        end
      end
      S_SOUND: begin
        freq_nxt  = rd_freq16;
        tone_nxt  = (rd_freq != '0);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_ok) begin
          fin_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      index_r     <= '0;
      len_r       <= '0;
      elapsed_r   <= '0;
      scaled_r    <= '0;
      playing_r   <= 1'b0;
      tone_r      <= 1'b0;
      freq_r      <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      index_r   <= index_nxt;
      len_r     <= len_nxt;
      elapsed_r <= elapsed_nxt;
      scaled_r  <= scaled_nxt;
      playing_r <= playing_nxt;
      tone_r    <= tone_nxt;
      freq_r    <= freq_nxt;
      fin_r     <= fin_nxt;
      // result register: loads on emit, drains when taken
      if ((state_r == S_EMIT) && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if ((state_r == S_EMIT) && emit_ok) begin
      out_data_r.tone_freq     <= tone_r ? freq_r : 16'd0;
      out_data_r.sounding      <= tone_r;
      out_data_r.playing       <= playing_r;
      out_data_r.finished      <= fin_r;
      out_data_r.note_position <= index_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mnsq_note_mem #(
    .DEPTH     (TABLE_DEPTH),
    .AW        (AW),
    .FREQ_BITS (FREQ_BITS)
  ) u_note_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_freq (wr_freq),
    .wr_dur  (in_data.entry_duration),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_freq (rd_freq),
    .rd_dur  (rd_dur)
  );

`include "assert_macros.svh"

  // one request at a time: intake closes right after an accept
  `ASSERT_NEXT(a_one_at_a_time, accept, in_stall)
  // while playing, the note index stays inside the melody
  `ASSERT_IMPLY(a_index_in_range, playing_r, index_r < len_r)
  // an active tone always has a real frequency behind it
  `ASSERT_IMPLY(a_tone_has_freq, tone_r, freq_r != 16'd0)
  // a finishing result never claims play is still running
  `ASSERT_IMPLY(a_fin_stopped, out_valid_r && out_data_r.finished,
                !out_data_r.playing && !out_data_r.sounding)

endmodule
`default_nettype wire
